// File: hw/rtl/ptb_pkg.sv
package ptb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int LIST_DEPTH = 32;
  localparam int FRAC_BITS  = 8;

  localparam int OP_W     = 3;
  localparam int ID_W     = 4;
  localparam int IVL_W    = 16;
  localparam int CNT_W    = 17;
  localparam int DELTA_W  = 24;
  localparam int SCALE_W  = 16;

  localparam int TIMER_W  = $clog2(NUM_TIMERS);
  localparam int IDX_W    = $clog2(LIST_DEPTH);
  localparam int LEN_W    = $clog2(LIST_DEPTH + 1);
  localparam int RELOAD_W = IVL_W + FRAC_BITS;
  localparam int WAIT_W   = RELOAD_W + 1;
  localparam int PROD_W   = DELTA_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << FRAC_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_INIT   = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PAUSE  = 3'd4,
    OP_RESUME = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCALE = 5'b00100,
    S_WALK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic push_rej;
    logic scale;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_tick;
    logic rej;
    logic walk_done;
    logic fire;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/ptb_ctrl.sv
module ptb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptb_pkg::sts_t sts,
  output ptb_pkg::cmd_t cmd
);
  import ptb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_tick ? S_SCALE : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.rej) begin
          if (sts.out_free) begin
            cmd.push_rej = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = S_FLUSH;
        end else if (!(sts.fire && sts.pend_valid && !sts.out_free)) begin
          cmd.step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/ptb_datapath.sv
module ptb_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [ptb_pkg::SCALE_W-1:0]         cfg_data,
  input  logic [ptb_pkg::OP_W-1:0]            operation,
  input  logic [ptb_pkg::ID_W-1:0]            timer_id,
  input  logic [ptb_pkg::IVL_W-1:0]           interval,
  input  logic signed [ptb_pkg::CNT_W-1:0]    repeat_count,
  input  logic [ptb_pkg::DELTA_W-1:0]         delta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                event_res,
  output logic [ptb_pkg::ID_W-1:0]            fired_id,
  output logic [ptb_pkg::DELTA_W-1:0]         scaled_delta,
  output logic                                last,
  input  ptb_pkg::cmd_t                       cmd,
  output ptb_pkg::sts_t                       sts
);
  import ptb_pkg::*;

  logic [SCALE_W-1:0]        time_scale;
  op_t                       op_r;
  logic [ID_W-1:0]           id_r;
  logic [IVL_W-1:0]          interval_r;
  logic signed [CNT_W-1:0]   count_r;
  logic [DELTA_W-1:0]        delta_r;
  logic [DELTA_W-1:0]        sdelta;

  logic [ID_W-1:0]           order_ids [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     order_valid;
  logic [LEN_W-1:0]          list_len;
  logic [RELOAD_W-1:0]       interval_store [NUM_TIMERS];
  logic signed [WAIT_W-1:0]  wait_left [NUM_TIMERS];
  logic signed [CNT_W-1:0]   count_left [NUM_TIMERS];
  logic [IDX_W-1:0]          slot_of [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]     paused;
  logic [NUM_TIMERS-1:0]     attached;
  logic [NUM_TIMERS-1:0]     listed;

  logic [LEN_W-1:0]          widx;
  logic [LEN_W-1:0]          keep;
  logic                      pend_valid;
  logic [ID_W-1:0]           pend_id;

  logic [TIMER_W-1:0]        tid;
  logic                      id_ok;
  logic                      full;
  logic                      rej;
  logic [IDX_W-1:0]          widx_i;
  logic [IDX_W-1:0]          keep_i;
  logic [ID_W-1:0]           ent_id;
  logic [TIMER_W-1:0]        et;
  logic                      ent_ok;
  logic signed [CNT_W-1:0]   cnt;
  logic signed [CNT_W-1:0]   cnt_after;
  logic                      active;
  logic signed [WAIT_W-1:0]  wnew;
  logic                      fire;
  logic                      kept;
  logic                      walk_done;
  logic                      out_free;
  logic [PROD_W-1:0]         prod;
  logic [DELTA_W-1:0]        sdelta_next;

  always_comb begin
    tid       = id_r[TIMER_W-1:0];
    id_ok     = (32'(id_r) < NUM_TIMERS);
    full      = (list_len == LEN_W'(LIST_DEPTH));
    rej       = (op_r == OP_ADD) && id_ok && !attached[tid] && !listed[tid] && full;
    widx_i    = widx[IDX_W-1:0];
    keep_i    = keep[IDX_W-1:0];
    ent_id    = order_ids[widx_i];
    et        = ent_id[TIMER_W-1:0];
    ent_ok    = order_valid[widx_i] && (32'(ent_id) < NUM_TIMERS);
    cnt       = count_left[et];
    active    = ent_ok && !paused[et] && (cnt != '0);
    wnew      = wait_left[et] - $signed(WAIT_W'(sdelta));
    fire      = active && wnew[WAIT_W-1];
    cnt_after = (fire && !cnt[CNT_W-1]) ? cnt - CNT_W'(1) : cnt;
    kept      = ent_ok && (cnt_after != '0);
    walk_done = (widx == list_len);
    out_free  = !out_valid || out_ready;
    prod      = PROD_W'(delta_r) * PROD_W'(time_scale);
    if (prod[PROD_W-1:FRAC_BITS+DELTA_W] != '0) begin
      sdelta_next = '1;
    end else begin
      sdelta_next = prod[FRAC_BITS+DELTA_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    sts            = '0;
    sts.in_tick    = (operation == OP_TICK);
    sts.rej        = rej;
    sts.walk_done  = walk_done;
    sts.fire       = fire;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale  <= SCALE_RESET;
      order_valid <= '0;
      list_len    <= '0;
      paused      <= '0;
      attached    <= '0;
      listed      <= '0;
      widx        <= '0;
      keep        <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_scale <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.push_rej) begin
        out_valid <= 1'b1;
      end
      if (cmd.exec && id_ok) begin
        case (op_r)
          OP_INIT: begin
            paused[tid]   <= 1'b0;
            attached[tid] <= 1'b0;
          end
          OP_ADD: begin
            if (!attached[tid]) begin
              attached[tid] <= 1'b1;
              if (!listed[tid]) begin
                order_valid[list_len[IDX_W-1:0]] <= 1'b1;
                listed[tid] <= 1'b1;
                list_len    <= list_len + LEN_W'(1);
              end
            end
          end
          OP_REMOVE: begin
            attached[tid] <= 1'b0;
            if (listed[tid]) begin
              order_valid[slot_of[tid]] <= 1'b0;
              listed[tid] <= 1'b0;
            end
          end
          OP_PAUSE:  paused[tid] <= 1'b1;
          OP_RESUME: paused[tid] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.scale) begin
        widx <= '0;
        keep <= '0;
      end
      if (cmd.step) begin
        if (fire) begin
          if (pend_valid) begin
            out_valid <= 1'b1;
          end
          pend_valid <= 1'b1;
        end
        if (!kept || keep != widx) begin
          order_valid[widx_i] <= 1'b0;
        end
        if (kept) begin
          order_valid[keep_i] <= 1'b1;
          keep <= keep + LEN_W'(1);
        end else if (ent_ok) begin
          listed[et] <= 1'b0;
        end
        widx <= widx + LEN_W'(1);
      end
      if (cmd.finish) begin
        list_len <= keep;
        if (pend_valid) begin
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op_t'(operation);
      id_r       <= timer_id;
      interval_r <= interval;
      count_r    <= repeat_count;
      delta_r    <= delta;
    end
    if (cmd.exec && id_ok) begin
      if (op_r == OP_INIT) begin
        interval_store[tid] <= RELOAD_W'(interval_r) << FRAC_BITS;
        wait_left[tid]      <= $signed({1'b0, RELOAD_W'(interval_r) << FRAC_BITS});
        count_left[tid]     <= count_r;
      end
      if (op_r == OP_ADD && !attached[tid] && !listed[tid]) begin
        order_ids[list_len[IDX_W-1:0]] <= id_r;
        slot_of[tid] <= list_len[IDX_W-1:0];
      end
    end
    if (cmd.scale) begin
      sdelta <= sdelta_next;
    end
    if (cmd.push_rej) begin
      event_res    <= 1'b1;
      fired_id     <= id_r;
      scaled_delta <= '0;
      last         <= 1'b1;
    end
    if (cmd.step) begin
      if (active) begin
        wait_left[et]  <= fire ? $signed({1'b0, interval_store[et]}) : wnew;
        count_left[et] <= cnt_after;
      end
      if (fire) begin
        if (pend_valid) begin
          event_res    <= 1'b0;
          fired_id     <= pend_id;
          scaled_delta <= sdelta;
          last         <= 1'b0;
        end
        pend_id <= ent_id;
      end
      if (kept) begin
        order_ids[keep_i] <= ent_id;
        slot_of[et]       <= keep_i;
      end
    end
    if (cmd.finish && pend_valid) begin
      event_res    <= 1'b0;
      fired_id     <= pend_id;
      scaled_delta <= sdelta;
      last         <= 1'b1;
    end
  end

  a_rej_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.push_rej |-> out_free) else $error("rejection pushed over a held word");
  a_fire_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && fire && pend_valid) |-> out_free) else $error("firing pushed over a held word");
  a_len: assert property (@(posedge clk) disable iff (rst)
    list_len <= LEN_W'(LIST_DEPTH)) else $error("list length beyond depth");
  a_step: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !walk_done) else $error("step past list end");
  a_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !pend_valid) else $error("pending firing kept after finish");

endmodule

// File: hw/rtl/periodic_timer_bank.sv
// channel  | handshake            | word
// cfg      | cfg_valid/cfg_ready  | cfg_data (time_scale)
// in       | in_valid/in_ready    | operation, timer_id, interval, repeat_count, delta
// out      | out_valid/out_ready  | event_res, fired_id, scaled_delta, last
//
// Init, add, remove, pause and resume pass through the exec state; a full-list add also waits
// for the output register. A tick passes through the scale, walk and flush states; the walk
// counts down, fires and compacts the list entries in a single pass.
// A held output word stalls the walk when a further firing needs the register, and
// holds the final firing at the end of the tick until the register frees.
// Synchronous reset: empty list, all flags clear, time_scale = 1.0.
module periodic_timer_bank (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptb_pkg::SCALE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ptb_pkg::OP_W-1:0]            operation,
  input  logic [ptb_pkg::ID_W-1:0]            timer_id,
  input  logic [ptb_pkg::IVL_W-1:0]           interval,
  input  logic signed [ptb_pkg::CNT_W-1:0]    repeat_count,
  input  logic [ptb_pkg::DELTA_W-1:0]         delta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                event_res,
  output logic [ptb_pkg::ID_W-1:0]            fired_id,
  output logic [ptb_pkg::DELTA_W-1:0]         scaled_delta,
  output logic                                last
);
  import ptb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .timer_id     (timer_id),
    .interval     (interval),
    .repeat_count (repeat_count),
    .delta        (delta),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .fired_id     (fired_id),
    .scaled_delta (scaled_delta),
    .last         (last),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// File: tb/tb_periodic_timer_bank.sv
`timescale 1ns / 100ps

module tb_periodic_timer_bank;
  import ptb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE = 3 + LIST_DEPTH + 25;

  typedef struct {
    logic             ev;
    logic [ID_W-1:0]  id;
    logic [DELTA_W-1:0] sd;
    logic             lst;
  } fire_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SCALE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] operation = '0;
  logic [ID_W-1:0] timer_id = '0;
  logic [IVL_W-1:0] interval = '0;
  logic signed [CNT_W-1:0] repeat_count = '0;
  logic [DELTA_W-1:0] delta = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic event_res;
  logic [ID_W-1:0] fired_id;
  logic [DELTA_W-1:0] scaled_delta;
  logic last;

  periodic_timer_bank u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [SCALE_W-1:0] scale_q = SCALE_RESET;
  logic [ID_W-1:0] slot_id [LIST_DEPTH];
  logic slot_live [LIST_DEPTH];
  int list_len = 0;
  longint reload [NUM_TIMERS];
  longint wait_cnt [NUM_TIMERS];
  int runs_left [NUM_TIMERS];
  logic paused [NUM_TIMERS];
  logic attached [NUM_TIMERS];
  logic inited [NUM_TIMERS];

  fire_word_t fire_q [$];
  int mismatches = 0;
  int words_seen = 0;
  int fires_seen = 0;
  int rejects_seen = 0;
  int items_sent = 0;
  int cycles = 0;

  int burst_left = 0;
  int gap_max = 4;
  int stall_pct = 30;
  int hold_cycles = 0;

  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      slot_live[i] = 1'b0;
      slot_id[i] = '0;
    end
    for (int t = 0; t < NUM_TIMERS; t++) begin
      paused[t] = 1'b0;
      attached[t] = 1'b0;
      inited[t] = 1'b0;
      reload[t] = 0;
      wait_cnt[t] = 0;
      runs_left[t] = 0;
    end
  end

  task automatic predict_timers(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic [IVL_W-1:0] ivl, logic signed [CNT_W-1:0] cnt,
                                logic [DELTA_W-1:0] dl);
    logic [PROD_W-1:0] prod;
    longint s;
    int keep;
    bit found;
    fire_word_t w;
    fire_word_t burst [$];
    case (op)
      OP_TICK: begin
        prod = PROD_W'(dl) * PROD_W'(scale_q);
        s = longint'(prod >> FRAC_BITS);
        if (s > 64'hFFFFFF) s = 64'hFFFFFF;
        for (int i = 0; i < list_len; i++) begin
          if (slot_live[i] && !paused[slot_id[i]] && runs_left[slot_id[i]] != 0) begin
            wait_cnt[slot_id[i]] -= s;
            if (wait_cnt[slot_id[i]] < 0) begin
              w.ev = 1'b0;
              w.id = slot_id[i];
              w.sd = DELTA_W'(s);
              w.lst = 1'b0;
              burst.push_back(w);
              wait_cnt[slot_id[i]] = reload[slot_id[i]];
              if (runs_left[slot_id[i]] > 0) runs_left[slot_id[i]]--;
            end
          end
        end
        keep = 0;
        for (int i = 0; i < list_len; i++) begin
          if (slot_live[i] && runs_left[slot_id[i]] != 0) begin
            slot_id[keep] = slot_id[i];
            slot_live[keep] = 1'b1;
            keep++;
          end
        end
        for (int i = keep; i < LIST_DEPTH; i++) slot_live[i] = 1'b0;
        list_len = keep;
        if (burst.size() > 0) burst[burst.size()-1].lst = 1'b1;
        foreach (burst[k]) fire_q.push_back(burst[k]);
      end
      OP_INIT: begin
        reload[id] = longint'(ivl) << FRAC_BITS;
        wait_cnt[id] = reload[id];
        runs_left[id] = int'(cnt);
        paused[id] = 1'b0;
        attached[id] = 1'b0;
      end
      OP_ADD: begin
        if (!attached[id]) begin
          found = 1'b0;
          for (int i = 0; i < list_len; i++)
            if (slot_live[i] && slot_id[i] == id) found = 1'b1;
          if (found) begin
            attached[id] = 1'b1;
          end else if (list_len >= LIST_DEPTH) begin
            w.ev = 1'b1;
            w.id = id;
            w.sd = '0;
            w.lst = 1'b1;
            fire_q.push_back(w);
          end else begin
            attached[id] = 1'b1;
            slot_id[list_len] = id;
            slot_live[list_len] = 1'b1;
            list_len++;
          end
        end
      end
      OP_REMOVE: begin
        attached[id] = 1'b0;
        found = 1'b0;
        for (int i = 0; i < list_len; i++) begin
          if (!found && slot_live[i] && slot_id[i] == id) begin
            slot_live[i] = 1'b0;
            found = 1'b1;
          end
        end
      end
      OP_PAUSE: paused[id] = 1'b1;
      OP_RESUME: paused[id] = 1'b0;
      default: ;
    endcase
  endtask

  // sender: bursts with random gaps; valid stays high between back-to-back words
  task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [IVL_W-1:0] ivl, logic signed [CNT_W-1:0] cnt,
                           logic [DELTA_W-1:0] dl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    timer_id <= id;
    interval <= ivl;
    repeat_count <= cnt;
    delta <= dl;
    do @(posedge clk); while (!in_ready);
    if (op == OP_INIT) inited[id] = 1'b1;
    predict_timers(op, id, ivl, cnt, dl);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (fire_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    scale_q = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(logic [DELTA_W-1:0] dl);
    send_word(OP_TICK, '0, '0, '0, dl);
  endtask

  task automatic send_init(logic [ID_W-1:0] id, logic [IVL_W-1:0] ivl,
                           logic signed [CNT_W-1:0] cnt);
    send_word(OP_INIT, id, ivl, cnt, '0);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
    send_word(op, id, IVL_W'($urandom), CNT_W'($urandom), DELTA_W'($urandom));
  endtask

  // receiver: random stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      fire_word_t w;
      words_seen++;
      if (event_res) rejects_seen++;
      else fires_seen++;
      if (fire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: ev=%0d id=%0d sd=%h last=%0d",
                   event_res, fired_id, scaled_delta, last);
      end else begin
        w = fire_q.pop_front();
        if (w.ev !== event_res || w.id !== fired_id || w.sd !== scaled_delta ||
            w.lst !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ev=%0d id=%0d sd=%h last=%0d got ev=%0d id=%0d sd=%h last=%0d",
                     w.ev, w.id, w.sd, w.lst, event_res, fired_id, scaled_delta, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, fire_q.size());
      $display("periodic_timer_bank regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_init(0, 0, -1);
    send_init(1, 16'hFFFF, 17'sd65535);
    send_init(2, 3, 1);
    send_init(3, 2, 0);
    send_op(OP_ADD, 0);
    send_op(OP_ADD, 1);
    send_op(OP_ADD, 2);
    send_op(OP_ADD, 3);
    send_op(OP_ADD, 2);
    send_tick(24'hFFFFFF);
    send_tick(0);
    send_op(OP_PAUSE, 0);
    send_tick(24'h000400);
    send_op(OP_RESUME, 0);
    send_tick(24'h000001);
    send_init(1, 1, 2);
    send_op(OP_ADD, 1);
    send_op(OP_REMOVE, 5);
    send_word(3'd6, 4'hF, 16'hFFFF, 17'h1FFFF, 24'hFFFFFF);
    send_word(3'd7, 4'hA, 16'h5555, 17'h0AAAA, 24'hAAAAAA);
    send_op(OP_REMOVE, 1);
    send_tick(24'h000800);
    send_tick(24'h7FFFFF);
  endtask

  task automatic test_full_list();
    drain_results();
    send_init(4, 1, 3);
    for (int k = 0; k < LIST_DEPTH + 1; k++) begin
      send_op(OP_ADD, 4);
      send_op(OP_REMOVE, 4);
    end
    send_op(OP_ADD, 4);
    send_tick(24'h000100);
  endtask

  task automatic test_scale();
    logic [SCALE_W-1:0] pick [4];
    pick[0] = '0;
    pick[1] = 16'hFFFF;
    pick[2] = 16'h0080;
    pick[3] = SCALE_RESET;
    for (int p = 0; p < 4; p++) begin
      write_scale(pick[p]);
      send_init(6, 1, -1);
      send_op(OP_ADD, 6);
      send_tick(24'hFFFFFF);
      send_tick(24'h000300);
      send_tick(DELTA_W'($urandom));
      send_op(OP_REMOVE, 6);
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    for (int t = 8; t < 14; t++) begin
      send_init(t[ID_W-1:0], 0, -1);
      send_op(OP_ADD, t[ID_W-1:0]);
    end
    gap_max = 0;
    hold_cycles = 600;
    repeat (20) send_tick(24'h000100);
    gap_max = 4;
    drain_results();
    for (int t = 8; t < 14; t++) send_op(OP_REMOVE, t[ID_W-1:0]);
    send_tick(0);
  endtask

  task automatic test_random(int n);
    int sel;
    logic [ID_W-1:0] id;
    logic signed [CNT_W-1:0] cnt;
    logic [IVL_W-1:0] ivl;
    logic [DELTA_W-1:0] dl;
    for (int k = 0; k < n; k++) begin
      if (k % 80 == 0) begin
        write_scale((k % 160 == 0) ? SCALE_W'($urandom) : SCALE_W'($urandom_range(64, 512)));
        stall_pct = $urandom_range(0, 60);
        gap_max = (k % 160 == 0) ? 0 : 6;
      end
      sel = $urandom_range(0, 99);
      id = ID_W'($urandom);
      if (sel < 40) begin
        dl = ($urandom_range(0, 9) == 0) ? DELTA_W'($urandom)
                                          : DELTA_W'($urandom_range(0, 2048));
        send_tick(dl);
      end else if (sel < 60 || (sel < 75 && !inited[id])) begin
        if (!inited[id]) send_init(id, IVL_W'($urandom_range(0, 8)), CNT_W'($urandom_range(1, 4)));
        send_op(OP_ADD, id);
      end else if (sel < 75) begin
        ivl = ($urandom_range(0, 7) == 0) ? IVL_W'($urandom) : IVL_W'($urandom_range(0, 10));
        case ($urandom_range(0, 3))
          0: cnt = -1;
          1: cnt = CNT_W'($urandom);
          default: cnt = CNT_W'($urandom_range(0, 5));
        endcase
        send_init(id, ivl, cnt);
      end else if (sel < 85) begin
        send_op(OP_REMOVE, id);
      end else if (sel < 91) begin
        send_op(OP_PAUSE, id);
      end else if (sel < 97) begin
        send_op(OP_RESUME, id);
      end else begin
        send_word(OP_W'($urandom_range(6, 7)), id, IVL_W'($urandom), CNT_W'($urandom),
                  DELTA_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_scale();
    test_backpressure();
    test_random(200);
    drain_results();
    $display("sent %0d words; checked %0d results (%0d firings, %0d rejections)",
             items_sent, words_seen, fires_seen, rejects_seen);
    $display("covered all operations, full list, scale extremes, long output hold-off");
    if (mismatches == 0 && fire_q.size() == 0) begin
      $display("periodic_timer_bank regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, fire_q.size());
      $display("periodic_timer_bank regression: fail");
    end
    $finish;
  end

endmodule
